FILE: src/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants for the segment/triangle crossing test
// Item and result layouts, miss codes, register map and internal widths.
// ----------------------------------------------------------------------------
package sti_pkg;

  // Width of a coordinate field at the ports.
  localparam int FIELD_WIDTH = 16;

  // Bit from which a coordinate is sign extended is COORD_WIDTH-1.
  localparam int COORD_WIDTH = 16;

  // Internal coordinate width: one more than the field, so that a value that
  // reads as non-negative (COORD_WIDTH above the field) still fits.
  localparam int CW  = FIELD_WIDTH + 1;
  localparam int EW  = CW + 1;          // edges and the negated first corner
  localparam int PPW = CW + EW;         // products that build pvec
  localparam int PW  = PPW + 1;         // pvec
  localparam int QPW = EW + EW;         // products that build qvec
  localparam int QW  = QPW + 1;         // qvec
  localparam int DPW = EW + QW;         // widest dot product term
  localparam int DW  = DPW + 3;         // dot sums, with room for negation
  localparam int SW  = DW + 1;          // u + v numerator

  // Shift used to sign extend from bit COORD_WIDTH-1 of a field.
  localparam int CoordShift = (COORD_WIDTH >= CW) ? 0 : CW - COORD_WIDTH;

  // Configuration register map.
  localparam int ADDR_WIDTH = 2;
  localparam logic [ADDR_WIDTH-1:0] REG_DET_EPSILON = 2'd0;
  localparam logic [31:0] DET_EPSILON_RESET = 32'd4398047;

  typedef enum logic [2:0] {
    MISS_NONE     = 3'd0,
    MISS_PARALLEL = 3'd1,
    MISS_U        = 3'd2,
    MISS_V        = 3'd3,
    MISS_T        = 3'd4
  } miss_reason_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] a_x;
    logic signed [FIELD_WIDTH-1:0] a_y;
    logic signed [FIELD_WIDTH-1:0] a_z;
    logic signed [FIELD_WIDTH-1:0] b_x;
    logic signed [FIELD_WIDTH-1:0] b_y;
    logic signed [FIELD_WIDTH-1:0] b_z;
    logic signed [FIELD_WIDTH-1:0] c_x;
    logic signed [FIELD_WIDTH-1:0] c_y;
    logic signed [FIELD_WIDTH-1:0] c_z;
    logic signed [FIELD_WIDTH-1:0] end_x;
    logic signed [FIELD_WIDTH-1:0] end_y;
    logic signed [FIELD_WIDTH-1:0] end_z;
  } item_t;

  typedef struct packed {
    logic         hit;
    miss_reason_t miss_reason;
  } result_t;

  // Interpret a raw field as a coordinate of COORD_WIDTH bits.
  function automatic logic signed [CW-1:0] coord(input logic [FIELD_WIDTH-1:0] raw);
    logic [CW-1:0] ext;
    logic [CW-1:0] shifted;
    begin
      if (COORD_WIDTH >= CW) begin
        ext = {1'b0, raw};
        coord = $signed(ext);
      end else begin
        ext = {raw[FIELD_WIDTH-1], raw};
        shifted = ext << CoordShift;
        coord = $signed(shifted) >>> CoordShift;
      end
    end
  endfunction

endpackage

FILE: src/segment_triangle_intersect_top.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect_top: pipelined segment/triangle crossing test
// Moller-Trumbore test without division, one item per cycle.
// ----------------------------------------------------------------------------
// A result passes through the six register stages after the one that takes
// its item, stages 2 to 6 and the result register. Throughput: one item per
// cycle while the result side is not stalled, because every stage loads a new
// item whenever its content moves on. A stall on the result side fills empty
// stages first and reaches item_stall only when all stages hold items. Reset
// (synchronous, active high) empties the pipeline and loads det_epsilon with
// its default; there is no clearing pass.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_top (
  input  logic                             clk,
  input  logic                             rst,
  // Item channel.
  input  logic                             item_valid,
  output logic                             item_stall,
  input  sti_pkg::item_t                   item,
  // Result channel.
  output logic                             result_valid,
  input  logic                             result_stall,
  output sti_pkg::result_t                 result,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sti_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CW  = sti_pkg::CW;
  localparam int EW  = sti_pkg::EW;
  localparam int PPW = sti_pkg::PPW;
  localparam int PW  = sti_pkg::PW;
  localparam int QPW = sti_pkg::QPW;
  localparam int QW  = sti_pkg::QW;
  localparam int DPW = sti_pkg::DPW;
  localparam int DW  = sti_pkg::DW;
  localparam int SW  = sti_pkg::SW;

  // --------------------------------------------------------------------------
  // Configuration register. Writes complete in the access phase.
  // --------------------------------------------------------------------------
  logic [31:0] det_epsilon;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == sti_pkg::REG_DET_EPSILON);
  assign prdata    = (paddr == sti_pkg::REG_DET_EPSILON) ? det_epsilon : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= sti_pkg::DET_EPSILON_RESET;
    end else if (cfg_write) begin
      det_epsilon <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. Stage k loads when it is empty or its content moves on.
  // Stage 7 is the result register itself.
  // --------------------------------------------------------------------------
  logic [6:1] vld;
  logic [7:1] en;

  assign en[7] = !result_valid || !result_stall;
  assign en[6] = !vld[6] || en[7];
  assign en[5] = !vld[5] || en[6];
  assign en[4] = !vld[4] || en[5];
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign item_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (en[1]) vld[1] <= item_valid;
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
      if (en[6]) vld[6] <= vld[5];
      if (en[7]) result_valid <= vld[6];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: edges. dir = end, e1 = b - a, e2 = c - a, tvec = -a.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] s1_dir [3];
  logic signed [EW-1:0] s1_e1  [3];
  logic signed [EW-1:0] s1_e2  [3];
  logic signed [EW-1:0] s1_tv  [3];

  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] cc [3];
  logic signed [CW-1:0] cd [3];

  always_comb begin
    ca[0] = sti_pkg::coord(item.a_x);
    ca[1] = sti_pkg::coord(item.a_y);
    ca[2] = sti_pkg::coord(item.a_z);
    cb[0] = sti_pkg::coord(item.b_x);
    cb[1] = sti_pkg::coord(item.b_y);
    cb[2] = sti_pkg::coord(item.b_z);
    cc[0] = sti_pkg::coord(item.c_x);
    cc[1] = sti_pkg::coord(item.c_y);
    cc[2] = sti_pkg::coord(item.c_z);
    cd[0] = sti_pkg::coord(item.end_x);
    cd[1] = sti_pkg::coord(item.end_y);
    cd[2] = sti_pkg::coord(item.end_z);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_dir[i] <= cd[i];
        s1_e1[i]  <= EW'(cb[i]) - EW'(ca[i]);
        s1_e2[i]  <= EW'(cc[i]) - EW'(ca[i]);
        s1_tv[i]  <= -EW'(ca[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the twelve products of pvec = dir x e2 and qvec = tvec x e1.
  // Term pa[i] - pb[i] gives pvec[i]; qa[i] - qb[i] gives qvec[i].
  // --------------------------------------------------------------------------
  logic signed [PPW-1:0] s2_pa [3];
  logic signed [PPW-1:0] s2_pb [3];
  logic signed [QPW-1:0] s2_qa [3];
  logic signed [QPW-1:0] s2_qb [3];
  logic signed [CW-1:0]  s2_dir [3];
  logic signed [EW-1:0]  s2_e1  [3];
  logic signed [EW-1:0]  s2_e2  [3];
  logic signed [EW-1:0]  s2_tv  [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_pa[0] <= PPW'(s1_dir[1]) * PPW'(s1_e2[2]);
      s2_pb[0] <= PPW'(s1_dir[2]) * PPW'(s1_e2[1]);
      s2_pa[1] <= PPW'(s1_dir[2]) * PPW'(s1_e2[0]);
      s2_pb[1] <= PPW'(s1_dir[0]) * PPW'(s1_e2[2]);
      s2_pa[2] <= PPW'(s1_dir[0]) * PPW'(s1_e2[1]);
      s2_pb[2] <= PPW'(s1_dir[1]) * PPW'(s1_e2[0]);
      s2_qa[0] <= QPW'(s1_tv[1]) * QPW'(s1_e1[2]);
      s2_qb[0] <= QPW'(s1_tv[2]) * QPW'(s1_e1[1]);
      s2_qa[1] <= QPW'(s1_tv[2]) * QPW'(s1_e1[0]);
      s2_qb[1] <= QPW'(s1_tv[0]) * QPW'(s1_e1[2]);
      s2_qa[2] <= QPW'(s1_tv[0]) * QPW'(s1_e1[1]);
      s2_qb[2] <= QPW'(s1_tv[1]) * QPW'(s1_e1[0]);
      s2_dir <= s1_dir;
      s2_e1  <= s1_e1;
      s2_e2  <= s1_e2;
      s2_tv  <= s1_tv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pvec and qvec.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s3_pv  [3];
  logic signed [QW-1:0] s3_qv  [3];
  logic signed [CW-1:0] s3_dir [3];
  logic signed [EW-1:0] s3_e1  [3];
  logic signed [EW-1:0] s3_e2  [3];
  logic signed [EW-1:0] s3_tv  [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_pv[i] <= PW'(s2_pa[i]) - PW'(s2_pb[i]);
        s3_qv[i] <= QW'(s2_qa[i]) - QW'(s2_qb[i]);
      end
      s3_dir <= s2_dir;
      s3_e1  <= s2_e1;
      s3_e2  <= s2_e2;
      s3_tv  <= s2_tv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: dot product terms for det, u, v and t numerators.
  // --------------------------------------------------------------------------
  logic signed [DPW-1:0] s4_det [3];
  logic signed [DPW-1:0] s4_un  [3];
  logic signed [DPW-1:0] s4_vn  [3];
  logic signed [DPW-1:0] s4_tn  [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_det[i] <= DPW'(s3_e1[i])  * DPW'(s3_pv[i]);
        s4_un[i]  <= DPW'(s3_tv[i])  * DPW'(s3_pv[i]);
        s4_vn[i]  <= DPW'(s3_dir[i]) * DPW'(s3_qv[i]);
        s4_tn[i]  <= DPW'(s3_e2[i])  * DPW'(s3_qv[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: dot product sums.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s5_det;
  logic signed [DW-1:0] s5_un;
  logic signed [DW-1:0] s5_vn;
  logic signed [DW-1:0] s5_tn;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_det <= DW'(s4_det[0]) + DW'(s4_det[1]) + DW'(s4_det[2]);
      s5_un  <= DW'(s4_un[0])  + DW'(s4_un[1])  + DW'(s4_un[2]);
      s5_vn  <= DW'(s4_vn[0])  + DW'(s4_vn[1])  + DW'(s4_vn[2]);
      s5_tn  <= DW'(s4_tn[0])  + DW'(s4_tn[1])  + DW'(s4_tn[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: fold the sign of det into the numerators and test for a
  // parallel segment. A zero determinant is parallel even with a zero
  // threshold.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s6_adet;
  logic signed [DW-1:0] s6_un;
  logic signed [DW-1:0] s6_vn;
  logic signed [DW-1:0] s6_tn;
  logic                 s6_par;

  logic                 det_neg;
  logic signed [DW-1:0] adet;
  logic signed [DW-1:0] eps_ext;

  always_comb begin
    det_neg = s5_det < 0;
    adet    = det_neg ? -s5_det : s5_det;
    eps_ext = DW'({1'b0, det_epsilon});
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_adet <= adet;
      s6_un   <= det_neg ? -s5_un : s5_un;
      s6_vn   <= det_neg ? -s5_vn : s5_vn;
      s6_tn   <= det_neg ? -s5_tn : s5_tn;
      s6_par  <= (s5_det == '0) || (adet < eps_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: range tests in order parallel, u, v and u+v, t. Boundaries
  // count as inside.
  // --------------------------------------------------------------------------
  sti_pkg::miss_reason_t reason;
  logic signed [SW-1:0]  uv_sum;

  always_comb begin
    uv_sum = SW'(s6_un) + SW'(s6_vn);
    if (s6_par) begin
      reason = sti_pkg::MISS_PARALLEL;
    end else if (s6_un < 0 || s6_un > s6_adet) begin
      reason = sti_pkg::MISS_U;
    end else if (s6_vn < 0 || uv_sum > SW'(s6_adet)) begin
      reason = sti_pkg::MISS_V;
    end else if (s6_tn < 0 || s6_tn > s6_adet) begin
      reason = sti_pkg::MISS_T;
    end else begin
      reason = sti_pkg::MISS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      result.hit         <= (reason == sti_pkg::MISS_NONE);
      result.miss_reason <= reason;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The input stalls only when every stage holds an item and the result waits.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (&vld) && result_valid && result_stall)
    else $error("item stalled while the pipeline has an empty stage");

  // The hit flag agrees with the miss code.
  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hit == (result.miss_reason == sti_pkg::MISS_NONE)))
    else $error("hit flag disagrees with miss code");

  // The threshold changes only through a register write.
  a_eps_write: assert property (@(posedge clk) disable iff (rst)
    !$stable(det_epsilon) |-> $past(cfg_write))
    else $error("det_epsilon changed without a write");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && (vld == '0))
    else $error("pipeline not empty after reset");

  // An item in stage 6 with a free output reaches the result next cycle.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    vld[6] && en[7] |=> result_valid)
    else $error("item lost between last stage and result");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the segment/triangle crossing test
// Drives triangle and segment items under random gaps and output stalls,
// predicts hit and miss reason with exact 64-bit integer arithmetic, and
// checks every result in order. det_epsilon is swept through several
// values, the extremes among them, between runs of items.
// ----------------------------------------------------------------------------
module tb_top;

  // Components of a vector at full 64-bit precision. Products of Q2.14
  // coordinates stay well below 2^63, so nothing here can overflow.
  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  // Holds the verdicts predicted for accepted items, oldest first, and
  // compares them against what the block produces.
  class crossing_scoreboard;
    sti_pkg::miss_reason_t pending_verdicts[$];
    logic [31:0]           det_eps;
    int                    errors;

    function new();
      det_eps = sti_pkg::DET_EPSILON_RESET;
      errors  = 0;
    endfunction

    // Take the low field bits and sign extend from bit COORD_WIDTH-1.
    function longint to_coord(logic [sti_pkg::FIELD_WIDTH-1:0] raw);
      longint v;
      longint sgn;
      v = raw;
      if (sti_pkg::COORD_WIDTH > sti_pkg::FIELD_WIDTH) return v;
      sgn = longint'(1) << (sti_pkg::COORD_WIDTH - 1);
      v = v & ((sgn << 1) - 1);
      if ((v & sgn) != 0) v = v - (sgn << 1);
      return v;
    endfunction

    function vec3_t diff_of(vec3_t p, vec3_t q);
      vec3_t r;
      r.x = p.x - q.x;
      r.y = p.y - q.y;
      r.z = p.z - q.z;
      return r;
    endfunction

    function vec3_t cross_of(vec3_t p, vec3_t q);
      vec3_t r;
      r.x = p.y * q.z - p.z * q.y;
      r.y = p.z * q.x - p.x * q.z;
      r.z = p.x * q.y - p.y * q.x;
      return r;
    endfunction

    function longint dot_of(vec3_t p, vec3_t q);
      return p.x * q.x + p.y * q.y + p.z * q.z;
    endfunction

    // Division-free crossing test: numerators are compared against det
    // after both are brought to a positive det.
    function sti_pkg::miss_reason_t classify(sti_pkg::item_t it);
      vec3_t  a, b, c, d, e1, e2, tv, pv, qv, zero;
      longint det, adet, un, vn, tn, eps;
      zero = '0;
      a.x = to_coord(it.a_x);   a.y = to_coord(it.a_y);   a.z = to_coord(it.a_z);
      b.x = to_coord(it.b_x);   b.y = to_coord(it.b_y);   b.z = to_coord(it.b_z);
      c.x = to_coord(it.c_x);   c.y = to_coord(it.c_y);   c.z = to_coord(it.c_z);
      d.x = to_coord(it.end_x); d.y = to_coord(it.end_y); d.z = to_coord(it.end_z);
      e1 = diff_of(b, a);
      e2 = diff_of(c, a);
      tv = diff_of(zero, a);
      pv = cross_of(d, e2);
      det = dot_of(e1, pv);
      adet = (det < 0) ? -det : det;
      eps = det_eps;
      // A zero determinant is parallel even when the threshold is zero.
      if (det == 0 || adet < eps) return sti_pkg::MISS_PARALLEL;
      qv = cross_of(tv, e1);
      un = dot_of(tv, pv);
      vn = dot_of(d, qv);
      tn = dot_of(e2, qv);
      if (det < 0) begin
        un = -un;
        vn = -vn;
        tn = -tn;
      end
      // Boundaries are inclusive; the first failing test names the miss.
      if (un < 0 || un > adet) return sti_pkg::MISS_U;
      if (vn < 0 || un + vn > adet) return sti_pkg::MISS_V;
      if (tn < 0 || tn > adet) return sti_pkg::MISS_T;
      return sti_pkg::MISS_NONE;
    endfunction

    function void note_item(sti_pkg::item_t it);
      pending_verdicts = {pending_verdicts, classify(it)};
    endfunction

    function void check_result(sti_pkg::result_t got);
      sti_pkg::miss_reason_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with no item outstanding: hit=%0b miss_reason=%0d",
               got.hit, got.miss_reason);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.hit !== (want == sti_pkg::MISS_NONE)) begin
        $error("hit: expected %0b, actual %0b", want == sti_pkg::MISS_NONE, got.hit);
        errors++;
      end
      if (got.miss_reason !== want) begin
        $error("miss_reason: expected %0d, actual %0d", want, got.miss_reason);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           item_valid   = 1'b0;
  logic                           item_stall;
  sti_pkg::item_t                 item         = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  sti_pkg::result_t               result;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [sti_pkg::ADDR_WIDTH-1:0] paddr        = '0;
  logic [31:0]                    pwdata       = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  // When set, neither side idles: no item gaps and no result stalls.
  bit                             calm         = 1'b0;

  crossing_scoreboard             sb;
  logic [31:0]                    eps_plan [6];

  segment_triangle_intersect_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Uniform random integer in [-2^bits, 2^bits - 1].
  function automatic int rsig(input int bits);
    return int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits);
  endfunction

  function automatic logic [sti_pkg::FIELD_WIDTH-1:0] extreme_field();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      4:       return 16'h7FFF;
      default: return 16'h4000;
    endcase
  endfunction

  // Builds a triangle around the point P = t * end, with t = k8/8, so that
  // P = a + (u4/4) * e1 + (v4/4) * e2. With end a multiple of 8 and the edges
  // multiples of 4 every value is exact, so boundary cases land on the
  // boundary. Swapping the edges (and u with v) flips the sign of det.
  function automatic sti_pkg::item_t crossing(input int dx, input int dy, input int dz,
                                              input int fx, input int fy, input int fz,
                                              input int gx, input int gy, input int gz,
                                              input int k8, input int u4, input int v4);
    sti_pkg::item_t it;
    int             ax, ay, az;
    ax = dx * k8 / 8 - (u4 * fx + v4 * gx) / 4;
    ay = dy * k8 / 8 - (u4 * fy + v4 * gy) / 4;
    az = dz * k8 / 8 - (u4 * fz + v4 * gz) / 4;
    it.a_x   = 16'(ax);      it.a_y   = 16'(ay);      it.a_z   = 16'(az);
    it.b_x   = 16'(ax + fx); it.b_y   = 16'(ay + fy); it.b_z   = 16'(az + fz);
    it.c_x   = 16'(ax + gx); it.c_y   = 16'(ay + gy); it.c_z   = 16'(az + gz);
    it.end_x = 16'(dx);      it.end_y = 16'(dy);      it.end_z = 16'(dz);
    return it;
  endfunction

  // Presents one item, holds it through stalls, and records it at the edge
  // where it is taken. Valid is left high; the caller lowers it when done.
  task automatic send_item(input sti_pkg::item_t it);
    while (!calm && $urandom_range(99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // Mostly well-formed crossings with random geometry and scale, the rest
  // broken crossings, raw noise, extreme fields and degenerate cases with a zero determinant.
  task automatic random_items(input int count);
    sti_pkg::item_t    it;
    logic [12*16-1:0]  raw;
    int                dx, dy, dz, fx, fy, fz, gx, gy, gz, k8, u4, v4, sel, sd, se;
    for (int n = 0; n < count; n++) begin
      sd = $urandom_range(0, 11);
      se = $urandom_range(0, 11);
      dx = rsig(sd) * 8; dy = rsig(sd) * 8; dz = rsig(sd) * 8;
      fx = rsig(se) * 4; fy = rsig(se) * 4; fz = rsig(se) * 4;
      gx = rsig(se) * 4; gy = rsig(se) * 4; gz = rsig(se) * 4;
      k8 = $urandom_range(0, 8);
      u4 = $urandom_range(0, 4);
      v4 = $urandom_range(0, 4 - u4);
      sel = $urandom_range(99);
      if (sel >= 55 && sel < 75) begin
        // One coordinate of the crossing point is pushed out of range.
        case ($urandom_range(2))
          0: u4 = $urandom_range(1) ? -int'($urandom_range(1, 3))
                                    : 4 + int'($urandom_range(1, 3));
          1: v4 = $urandom_range(1) ? -int'($urandom_range(1, 3))
                                    : 4 - u4 + int'($urandom_range(1, 3));
          default: k8 = $urandom_range(1) ? -int'($urandom_range(1, 4))
                                          : 8 + int'($urandom_range(1, 4));
        endcase
      end else if (sel >= 93) begin
        // Degenerate cases whose determinant is exactly zero.
        case ($urandom_range(2))
          0: begin dx = 0; dy = 0; dz = 0; end
          1: begin gx = 2 * fx; gy = 2 * fy; gz = 2 * fz; end
          default: begin dx = fx + gx; dy = fy + gy; dz = fz + gz; end
        endcase
      end
      if ($urandom_range(1))
        it = crossing(dx, dy, dz, fx, fy, fz, gx, gy, gz, k8, u4, v4);
      else
        it = crossing(dx, dy, dz, gx, gy, gz, fx, fy, fz, k8, v4, u4);
      if (sel >= 75 && sel < 87) begin
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (sel >= 87 && sel < 93) begin
        for (int i = 0; i < 12; i++) raw[i*16 +: 16] = extreme_field();
        it = raw;
      end
      send_item(it);
    end
    item_valid <= 1'b0;
  endtask

  // Writes det_epsilon through the APB port and reads it back.
  task automatic set_det_epsilon(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sti_pkg::REG_DET_EPSILON;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.det_eps = value;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $error("det_epsilon: expected %0d, actual %0d", value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: check whatever is taken at each edge, then pick the stall
  // for the next cycle. Values read right after the edge are the ones the
  // block saw at that edge.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result);
      result_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
    end
  end

  // Main sequence.
  initial begin
    sb = new();
    eps_plan = '{32'd0, 32'hFFFF_FFFF, 32'd128, 32'd129, $urandom,
                 sti_pkg::DET_EPSILON_RESET};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset value of det_epsilon. Degenerate and
    // extreme inputs first.
    send_item('0);
    send_item({12{16'h7FFF}});
    send_item({12{16'h8000}});
    send_item({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
               16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF});
    // A plain hit, and the same triangle wound the other way (det < 0).
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 1, 1));
    send_item(crossing(2048, -1024, 16384, 0, 8192, 0, 8192, 0, 0, 4, 1, 1));
    // Inclusive boundaries: corner a, edge u+v=1, corners b and c, t=1, t=0.
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 0, 0));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 2, 2));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 4, 0));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 0, 4));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 8, 1, 1));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 0, 1, 1));
    // Each miss on its own: u below 0 and above 1, v below 0, u+v above 1,
    // t above 1 and below 0, and v below 0 with det negative.
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, -1, 1));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 5, 0));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 1, -1));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, 3, 2));
    send_item(crossing(2048, -1024, 8192, 8192, 0, 0, 0, 8192, 0, 9, 1, 1));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, -1, 1, 1));
    send_item(crossing(2048, -1024, 16384, 0, 8192, 0, 8192, 0, 0, 4, 1, -1));
    // Test order: u before v, v before t, u before t.
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, 4, -1, -1));
    send_item(crossing(2048, -1024, 8192, 8192, 0, 0, 0, 8192, 0, 9, 1, -1));
    send_item(crossing(2048, -1024, 16384, 8192, 0, 0, 0, 8192, 0, -1, 5, 0));
    // A tiny triangle with |det| = 128: parallel at the reset threshold.
    send_item(crossing(0, 0, 8, 4, 0, 0, 0, 4, 0, 4, 1, 1));
    send_item(crossing(0, 0, 8, 0, 4, 0, 4, 0, 0, 4, 1, -1));
    random_items(300);

    // Sweep the threshold. The register is only touched once every result
    // of the previous run has come back, so the pipeline is empty. The
    // tiny triangle sits right at the 128/129 threshold boundary.
    foreach (eps_plan[p]) begin
      while (sb.outstanding() != 0) @(posedge clk);
      calm = (p == 2);
      set_det_epsilon(eps_plan[p]);
      send_item(crossing(0, 0, 8, 4, 0, 0, 0, 4, 0, 4, 1, 1));
      send_item(crossing(0, 0, 8, 0, 4, 0, 4, 0, 0, 4, 1, -1));
      random_items(250);
    end
    calm = 1'b0;

    // Drain, then leave room for any stray result beyond the latency.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 2000 items.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
